@@ src/bol_pkg.sv @@
// Shared types, constants and arithmetic helpers of the binomial option lattice.
`default_nettype none

package bol_pkg;

    // Default lattice depth.
    localparam int unsigned MAX_STEPS_DEF = 256;

    // Fixed-point constants.
    localparam logic [63:0] ONE_Q30_64 = 64'h0000_0000_4000_0000;
    localparam logic [31:0] ONE_Q30    = 32'h4000_0000;
    localparam logic [31:0] HALF_Q31   = 32'h4000_0000;
    localparam logic [31:0] ONE_Q31    = 32'h8000_0000;
    localparam logic [8:0]  STEPS_RST  = 9'd1;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_UP_FACTOR    = 3'd0,
        CFG_DOWN_FACTOR  = 3'd1,
        CFG_PROB_UP      = 3'd2,
        CFG_STEP_DISC    = 3'd3,
        CFG_STEPS        = 3'd4
    } t_cfg_idx;

    // Datapath operations.
    typedef enum logic [4:0] {
        DOP_NONE,
        DOP_START,
        DOP_MLO,
        DOP_MHI,
        DOP_MCMB,
        DOP_SET_UPW,
        DOP_SET_DPW,
        DOP_WR_PW,
        DOP_WR_LEAF,
        DOP_LOAD_V0,
        DOP_LOAD_V1,
        DOP_MIX_P,
        DOP_MIX_Q,
        DOP_MIX_M,
        DOP_MIX_D,
        DOP_MIX_V,
        DOP_EXER,
        DOP_WR_NODE
    } t_dop;

    // Operand pairs of the Q30 scaling multiply.
    typedef enum logic [1:0] {
        MQ_UP,
        MQ_DN,
        MQ_Y,
        MQ_AS
    } t_mq;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_CLR,
        CNT_INC
    } t_cnt;

    typedef enum logic {
        JOP_HOLD,
        JOP_DEC
    } t_jop;

    typedef struct packed {
        t_dop op;
        t_mq  mq;
        t_cnt i_op;
        t_jop j_op;
        logic nd_next;
    } t_cmd;

    typedef struct packed {
        logic i_eq_n;
        logic i_eq_j;
        logic j_zero;
        logic n_zero;
        logic amer;
    } t_stat;

    // Final step of a 64 by 32 Q30 multiply from its two partial products.
    function automatic logic [63:0] mq_combine(input logic [63:0] lo, input logic [63:0] hi);
        logic [63:0] t;
        logic [33:0] b;
        logic [64:0] s;
        t = lo + 64'h0000_0000_2000_0000;
        b = t[63:30];
        s = {1'b0, hi[61:0], 2'b00} + {31'd0, b};
        if (hi[63:62] != 2'b00 || s[64]) begin
            return '1;
        end
        return s[63:0];
    endfunction

    // Saturate to full scale of 32 bits.
    function automatic logic [31:0] sat32(input logic [63:0] v);
        if (v[63:32] != 32'd0) begin
            return '1;
        end
        return v[31:0];
    endfunction

    // Exercise value of a call or a put.
    function automatic logic [31:0] intrinsic(input logic [31:0] s, input logic [31:0] k,
                                              input logic put);
        if (put) begin
            return (k > s) ? (k - s) : 32'd0;
        end
        return (s > k) ? (s - k) : 32'd0;
    endfunction

endpackage

`default_nettype wire

@@ src/binomial_option_lattice.sv @@
// The single shared 32x32 multiplier computes three products per roll-back node, two more
// for an American exercise value. A new word is accepted only while busy is low; busy falls
// in the cycle after the strobe. Reset clears the state machine, counters and config regs.
// The result strobe lasts one cycle and the receiver cannot stall it.
`default_nettype none

module binomial_option_lattice
    import bol_pkg::*;
#(
    parameter int unsigned MAX_STEPS = MAX_STEPS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] i_spot_price,
    input  wire logic [31:0] i_strike_price,
    input  wire logic        i_is_put,
    input  wire logic        i_is_american,
    output logic             o_valid,
    output logic [31:0]      o_option_price
);

    logic [31:0] r_up_factor, r_down_factor, r_prob_up, r_step_discount;
    logic [8:0]  r_steps;
    t_cmd        w_cmd;
    t_stat       w_stat;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_factor     <= ONE_Q30;
            r_down_factor   <= ONE_Q30;
            r_prob_up       <= HALF_Q31;
            r_step_discount <= ONE_Q31;
            r_steps         <= STEPS_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_UP_FACTOR:   r_up_factor     <= i_cfg_data;
                CFG_DOWN_FACTOR: r_down_factor   <= i_cfg_data;
                CFG_PROB_UP:     r_prob_up       <= i_cfg_data;
                CFG_STEP_DISC:   r_step_discount <= i_cfg_data;
                CFG_STEPS:       r_steps         <= i_cfg_data[8:0];
                default: begin
                end
            endcase
        end
    end

    bol_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    bol_datapath #(
        .MAX_STEPS (MAX_STEPS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_up_factor     (r_up_factor),
        .i_down_factor   (r_down_factor),
        .i_prob_up       (r_prob_up),
        .i_step_discount (r_step_discount),
        .i_steps         (r_steps),
        .i_spot_price    (i_spot_price),
        .i_strike_price  (i_strike_price),
        .i_is_put        (i_is_put),
        .i_is_american   (i_is_american),
        .o_option_price  (o_option_price)
    );

endmodule

`default_nettype wire

@@ src/bol_datapath.sv @@
// Datapath of the lattice: shared multiplier, power, price and node memories, counters.
`default_nettype none

module bol_datapath
    import bol_pkg::*;
#(
    parameter int unsigned MAX_STEPS = MAX_STEPS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_stat            o_stat,
    input  wire logic [31:0] i_up_factor,
    input  wire logic [31:0] i_down_factor,
    input  wire logic [31:0] i_prob_up,
    input  wire logic [31:0] i_step_discount,
    input  wire logic [8:0]  i_steps,
    input  wire logic [31:0] i_spot_price,
    input  wire logic [31:0] i_strike_price,
    input  wire logic        i_is_put,
    input  wire logic        i_is_american,
    output logic [31:0]      o_option_price
);

    localparam int unsigned DEPTH = MAX_STEPS + 1;
    localparam int unsigned CW    = $clog2(DEPTH);

    // Memories: powers of the up factor, down-scaled spot prices, node values.
    logic [63:0] r_umem [DEPTH];
    logic [31:0] r_ymem [DEPTH];
    logic [31:0] r_nmem [DEPTH];

    logic [31:0] r_spot, r_strike;
    logic        r_put, r_amer;
    logic [CW-1:0] r_n, r_i, r_j;
    logic [63:0] r_upw, r_dpw, r_lo, r_hi, r_mq;
    logic [31:0] r_m, r_v, r_v0, r_v1;
    logic [63:0] r_uq;
    logic [31:0] r_yq, r_nq;

    logic [CW-1:0] w_nsteps, w_uaddr, w_naddr;
    logic [31:0]   w_p, w_q, w_disc;
    logic [63:0]   w_x, w_comb, w_prod, w_mix_sum, w_disc_sum;
    logic [31:0]   w_f, w_ma, w_mb, w_asset;

    // Clamp the lattice size and the Q1.31 factors.
    always_comb begin
        if ({23'd0, i_steps} > 32'(MAX_STEPS)) begin
            w_nsteps = CW'(MAX_STEPS);
        end else begin
            w_nsteps = CW'(i_steps);
        end
        w_p    = (i_prob_up > ONE_Q31) ? ONE_Q31 : i_prob_up;
        w_q    = ONE_Q31 - w_p;
        w_disc = (i_step_discount > ONE_Q31) ? ONE_Q31 : i_step_discount;
    end

    // Operands of the Q30 scaling multiply.
    always_comb begin
        unique case (i_cmd.mq)
            MQ_UP: begin
                w_x = r_upw;
                w_f = i_up_factor;
            end
            MQ_DN: begin
                w_x = r_dpw;
                w_f = i_down_factor;
            end
            MQ_Y: begin
                w_x = r_dpw;
                w_f = r_spot;
            end
            MQ_AS: begin
                w_x = r_uq;
                w_f = r_yq;
            end
            default: begin
                w_x = r_upw;
                w_f = i_up_factor;
            end
        endcase
    end

    // The one shared 32 by 32 multiplier.
    always_comb begin
        unique case (i_cmd.op)
            DOP_MLO: begin
                w_ma = w_x[31:0];
                w_mb = w_f;
            end
            DOP_MHI: begin
                w_ma = w_x[63:32];
                w_mb = w_f;
            end
            DOP_MIX_P: begin
                w_ma = w_p;
                w_mb = r_v0;
            end
            DOP_MIX_Q: begin
                w_ma = w_q;
                w_mb = r_v1;
            end
            DOP_MIX_D: begin
                w_ma = w_disc;
                w_mb = r_m;
            end
            default: begin
                w_ma = 32'd0;
                w_mb = 32'd0;
            end
        endcase
        w_prod = {32'd0, w_ma} * {32'd0, w_mb};
    end

    assign w_comb     = mq_combine(r_lo, r_hi);
    assign w_asset    = sat32(r_mq);
    assign w_mix_sum  = r_lo + r_hi + {32'd0, HALF_Q31};
    assign w_disc_sum = r_lo + {32'd0, HALF_Q31};
    assign w_uaddr    = r_j - r_i;
    assign w_naddr    = i_cmd.nd_next ? (r_i + CW'(1)) : r_i;

    // Counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i <= '0;
            r_j <= '0;
        end else begin
            unique case (i_cmd.i_op)
                CNT_CLR:  r_i <= '0;
                CNT_INC:  r_i <= r_i + CW'(1);
                default:  r_i <= r_i;
            endcase
            if (i_cmd.op == DOP_START) begin
                r_j <= w_nsteps;
            end else if (i_cmd.j_op == JOP_DEC) begin
                r_j <= r_j - CW'(1);
            end
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            DOP_START: begin
                r_spot   <= i_spot_price;
                r_strike <= i_strike_price;
                r_put    <= i_is_put;
                r_amer   <= i_is_american;
                r_n      <= w_nsteps;
                r_upw    <= ONE_Q30_64;
                r_dpw    <= ONE_Q30_64;
            end
            DOP_MLO:     r_lo  <= w_prod;
            DOP_MHI:     r_hi  <= w_prod;
            DOP_MCMB:    r_mq  <= w_comb;
            DOP_SET_UPW: r_upw <= w_comb;
            DOP_SET_DPW: r_dpw <= w_comb;
            DOP_WR_LEAF: r_v   <= intrinsic(w_asset, r_strike, r_put);
            DOP_LOAD_V0: r_v0  <= r_nq;
            DOP_LOAD_V1: r_v1  <= r_nq;
            DOP_MIX_P:   r_lo  <= w_prod;
            DOP_MIX_Q:   r_hi  <= w_prod;
            DOP_MIX_M:   r_m   <= w_mix_sum[62:31];
            DOP_MIX_D:   r_lo  <= w_prod;
            DOP_MIX_V:   r_v   <= w_disc_sum[62:31];
            DOP_EXER: begin
                if (intrinsic(w_asset, r_strike, r_put) > r_v) begin
                    r_v <= intrinsic(w_asset, r_strike, r_put);
                end
            end
            DOP_WR_NODE: r_v0  <= r_v1;
            default: begin
            end
        endcase
    end

    // Memory writes and registered reads.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DOP_WR_PW) begin
            r_umem[r_i] <= r_upw;
            r_ymem[r_i] <= w_asset;
        end
        if (i_cmd.op == DOP_WR_LEAF) begin
            r_nmem[r_i] <= intrinsic(w_asset, r_strike, r_put);
        end else if (i_cmd.op == DOP_WR_NODE) begin
            r_nmem[r_i] <= r_v;
        end
        r_uq <= r_umem[w_uaddr];
        r_yq <= r_ymem[r_i];
        r_nq <= r_nmem[w_naddr];
    end

    // Status for the controller.
    always_comb begin
        o_stat.i_eq_n = (r_i == r_n);
        o_stat.i_eq_j = (r_i == r_j);
        o_stat.j_zero = (r_j == '0);
        o_stat.n_zero = (r_n == '0);
        o_stat.amer   = r_amer;
    end

    assign o_option_price = r_v;

endmodule

`default_nettype wire

@@ src/bol_ctrl.sv @@
// Controller state machine that sequences the lattice datapath.
`default_nettype none

module bol_ctrl
    import bol_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd,
    output logic       o_busy,
    output logic       o_valid
);

    typedef enum logic [31:0] {
        S_IDLE    = 32'h0000_0001,
        S_PY_LO   = 32'h0000_0002,
        S_PY_HI   = 32'h0000_0004,
        S_PY_CB   = 32'h0000_0008,
        S_PY_WR   = 32'h0000_0010,
        S_PU_LO   = 32'h0000_0020,
        S_PU_HI   = 32'h0000_0040,
        S_PU_CB   = 32'h0000_0080,
        S_PD_LO   = 32'h0000_0100,
        S_PD_HI   = 32'h0000_0200,
        S_PD_CB   = 32'h0000_0400,
        S_LF_RD   = 32'h0000_0800,
        S_LF_LO   = 32'h0000_1000,
        S_LF_HI   = 32'h0000_2000,
        S_LF_CB   = 32'h0000_4000,
        S_LF_WR   = 32'h0000_8000,
        S_RL_INIT = 32'h0001_0000,
        S_RL_RD0  = 32'h0002_0000,
        S_RL_CAP0 = 32'h0004_0000,
        S_RL_RD1  = 32'h0008_0000,
        S_RL_CAP  = 32'h0010_0000,
        S_MX_P    = 32'h0020_0000,
        S_MX_Q    = 32'h0040_0000,
        S_MX_M    = 32'h0080_0000,
        S_MX_D    = 32'h0100_0000,
        S_MX_V    = 32'h0200_0000,
        S_AM_LO   = 32'h0400_0000,
        S_AM_HI   = 32'h0800_0000,
        S_AM_CB   = 32'h1000_0000,
        S_AM_EX   = 32'h2000_0000,
        S_NW      = 32'h4000_0000,
        S_DONE    = 32'h8000_0000
    } t_state;

    t_state r_state, n_state;

    // Next state and datapath command.
    always_comb begin
        n_state       = r_state;
        o_cmd.op      = DOP_NONE;
        o_cmd.mq      = MQ_UP;
        o_cmd.i_op    = CNT_HOLD;
        o_cmd.j_op    = JOP_HOLD;
        o_cmd.nd_next = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.op   = DOP_START;
                    o_cmd.i_op = CNT_CLR;
                    n_state    = S_PY_LO;
                end
            end
            S_PY_LO: begin
                o_cmd.op = DOP_MLO;
                o_cmd.mq = MQ_Y;
                n_state  = S_PY_HI;
            end
            S_PY_HI: begin
                o_cmd.op = DOP_MHI;
                o_cmd.mq = MQ_Y;
                n_state  = S_PY_CB;
            end
            S_PY_CB: begin
                o_cmd.op = DOP_MCMB;
                o_cmd.mq = MQ_Y;
                n_state  = S_PY_WR;
            end
            S_PY_WR: begin
                o_cmd.op = DOP_WR_PW;
                if (i_stat.i_eq_n) begin
                    o_cmd.i_op = CNT_CLR;
                    n_state    = S_LF_RD;
                end else begin
                    n_state = S_PU_LO;
                end
            end
            S_PU_LO: begin
                o_cmd.op = DOP_MLO;
                n_state  = S_PU_HI;
            end
            S_PU_HI: begin
                o_cmd.op = DOP_MHI;
                n_state  = S_PU_CB;
            end
            S_PU_CB: begin
                o_cmd.op = DOP_SET_UPW;
                n_state  = S_PD_LO;
            end
            S_PD_LO: begin
                o_cmd.op = DOP_MLO;
                o_cmd.mq = MQ_DN;
                n_state  = S_PD_HI;
            end
            S_PD_HI: begin
                o_cmd.op = DOP_MHI;
                o_cmd.mq = MQ_DN;
                n_state  = S_PD_CB;
            end
            S_PD_CB: begin
                o_cmd.op   = DOP_SET_DPW;
                o_cmd.mq   = MQ_DN;
                o_cmd.i_op = CNT_INC;
                n_state    = S_PY_LO;
            end
            S_LF_RD: begin
                n_state = S_LF_LO;
            end
            S_LF_LO: begin
                o_cmd.op = DOP_MLO;
                o_cmd.mq = MQ_AS;
                n_state  = S_LF_HI;
            end
            S_LF_HI: begin
                o_cmd.op = DOP_MHI;
                o_cmd.mq = MQ_AS;
                n_state  = S_LF_CB;
            end
            S_LF_CB: begin
                o_cmd.op = DOP_MCMB;
                o_cmd.mq = MQ_AS;
                n_state  = S_LF_WR;
            end
            S_LF_WR: begin
                o_cmd.op = DOP_WR_LEAF;
                if (!i_stat.i_eq_n) begin
                    o_cmd.i_op = CNT_INC;
                    n_state    = S_LF_RD;
                end else if (i_stat.n_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.j_op = JOP_DEC;
                    n_state    = S_RL_INIT;
                end
            end
            S_RL_INIT: begin
                o_cmd.i_op = CNT_CLR;
                n_state    = S_RL_RD0;
            end
            S_RL_RD0: begin
                n_state = S_RL_CAP0;
            end
            S_RL_CAP0: begin
                o_cmd.op      = DOP_LOAD_V0;
                o_cmd.nd_next = 1'b1;
                n_state       = S_RL_CAP;
            end
            S_RL_RD1: begin
                o_cmd.nd_next = 1'b1;
                n_state       = S_RL_CAP;
            end
            S_RL_CAP: begin
                o_cmd.op = DOP_LOAD_V1;
                n_state  = S_MX_P;
            end
            S_MX_P: begin
                o_cmd.op = DOP_MIX_P;
                n_state  = S_MX_Q;
            end
            S_MX_Q: begin
                o_cmd.op = DOP_MIX_Q;
                n_state  = S_MX_M;
            end
            S_MX_M: begin
                o_cmd.op = DOP_MIX_M;
                n_state  = S_MX_D;
            end
            S_MX_D: begin
                o_cmd.op = DOP_MIX_D;
                n_state  = S_MX_V;
            end
            S_MX_V: begin
                o_cmd.op = DOP_MIX_V;
                n_state  = i_stat.amer ? S_AM_LO : S_NW;
            end
            S_AM_LO: begin
                o_cmd.op = DOP_MLO;
                o_cmd.mq = MQ_AS;
                n_state  = S_AM_HI;
            end
            S_AM_HI: begin
                o_cmd.op = DOP_MHI;
                o_cmd.mq = MQ_AS;
                n_state  = S_AM_CB;
            end
            S_AM_CB: begin
                o_cmd.op = DOP_MCMB;
                o_cmd.mq = MQ_AS;
                n_state  = S_AM_EX;
            end
            S_AM_EX: begin
                o_cmd.op = DOP_EXER;
                o_cmd.mq = MQ_AS;
                n_state  = S_NW;
            end
            S_NW: begin
                o_cmd.op = DOP_WR_NODE;
                if (!i_stat.i_eq_j) begin
                    o_cmd.i_op = CNT_INC;
                    n_state    = S_RL_RD1;
                end else if (i_stat.j_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.j_op = JOP_DEC;
                    n_state    = S_RL_INIT;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

    // A result word is strobed for one cycle only.
    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    // An accepted word starts the power phase.
    a_start_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (r_state == S_PY_LO))
        else $error("accepted word did not start the power phase");

    // A result follows only the last leaf of a one-node lattice or the root node.
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |->
            (($past(r_state) == S_NW) && $past(i_stat.j_zero) && $past(i_stat.i_eq_j))
            || (($past(r_state) == S_LF_WR) && $past(i_stat.n_zero)))
        else $error("result strobed outside the end of the roll-back");

endmodule

`default_nettype wire

@@ dv/binomial_option_lattice_tb.sv @@
// Self-checking testbench of the binomial option lattice: queued stimulus, own pricing predictor.
`timescale 1ns / 1ps

module binomial_option_lattice_tb;
    import bol_pkg::*;

    localparam int unsigned LATTICE_MAX = 256;
    localparam int unsigned CYCLE_LIMIT = 2500000;

    typedef struct {
        logic [31:0] spot;
        logic [31:0] strike;
        logic        put;
        logic        amer;
    } t_option;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = 3'd0;
    logic [31:0] i_cfg_data = 32'd0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] i_spot_price = 32'd0;
    logic [31:0] i_strike_price = 32'd0;
    logic        i_is_put = 1'b0;
    logic        i_is_american = 1'b0;
    logic        o_valid;
    logic [31:0] o_option_price;

    // Shadow copy of the configuration registers.
    logic [31:0] sh_up = ONE_Q30;
    logic [31:0] sh_down = ONE_Q30;
    logic [31:0] sh_prob = HALF_Q31;
    logic [31:0] sh_disc = ONE_Q31;
    logic [8:0]  sh_steps = STEPS_RST;

    t_option     pending_options[$];
    logic [31:0] expected_prices[$];
    int          error_count = 0;
    int          idle_left = 0;
    bit          idle_on = 1'b1;
    int unsigned cycle_count = 0;

    binomial_option_lattice u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .start          (start),
        .busy           (busy),
        .i_spot_price   (i_spot_price),
        .i_strike_price (i_strike_price),
        .i_is_put       (i_is_put),
        .i_is_american  (i_is_american),
        .o_valid        (o_valid),
        .o_option_price (o_option_price)
    );

    // Clock with an 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Q30 scaling with round half up, saturated to 64 bits.
    function automatic logic [63:0] scale_q30(input logic [63:0] x, input logic [31:0] f);
        logic [95:0] prod;
        prod = ({32'd0, x} * {64'd0, f} + 96'h2000_0000) >> 30;
        if (prod[95:64] != 32'd0) begin
            return '1;
        end
        return prod[63:0];
    endfunction

    function automatic logic [31:0] clip32(input logic [63:0] v);
        return (v[63:32] != 32'd0) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic logic [31:0] exercise_value(input logic [31:0] s, input logic [31:0] k,
                                                   input logic put);
        if (put) begin
            return (k > s) ? k - s : 32'd0;
        end
        return (s > k) ? s - k : 32'd0;
    endfunction

    // Root value of one option on the lattice under the shadow configuration.
    function automatic logic [31:0] price_option(input t_option opt);
        logic [63:0] up_pw[0:LATTICE_MAX];
        logic [63:0] dn_pw[0:LATTICE_MAX];
        logic [31:0] vals[0:LATTICE_MAX];
        logic [63:0] p;
        logic [63:0] q;
        logic [63:0] disc;
        logic [63:0] m;
        logic [31:0] v;
        logic [31:0] s;
        int          n;
        p = (sh_prob > ONE_Q31) ? {32'd0, ONE_Q31} : {32'd0, sh_prob};
        q = {32'd0, ONE_Q31} - p;
        disc = (sh_disc > ONE_Q31) ? {32'd0, ONE_Q31} : {32'd0, sh_disc};
        n = (sh_steps > LATTICE_MAX) ? LATTICE_MAX : int'(sh_steps);
        up_pw[0] = ONE_Q30_64;
        dn_pw[0] = ONE_Q30_64;
        for (int k = 1; k <= n; k++) begin
            up_pw[k] = scale_q30(up_pw[k-1], sh_up);
            dn_pw[k] = scale_q30(dn_pw[k-1], sh_down);
        end
        for (int i = 0; i <= n; i++) begin
            s = clip32(scale_q30(up_pw[n-i], clip32(scale_q30(dn_pw[i], opt.spot))));
            vals[i] = exercise_value(s, opt.strike, opt.put);
        end
        for (int j = n - 1; j >= 0; j--) begin
            for (int i = 0; i <= j; i++) begin
                m = (p * vals[i] + q * vals[i+1] + 64'h4000_0000) >> 31;
                v = 32'((disc * m + 64'h4000_0000) >> 31);
                if (opt.amer) begin
                    s = clip32(scale_q30(up_pw[j-i], clip32(scale_q30(dn_pw[i], opt.spot))));
                    s = exercise_value(s, opt.strike, opt.put);
                    if (s > v) begin
                        v = s;
                    end
                end
                vals[i] = v;
            end
        end
        return vals[0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // Driver: presents queued words, with random idle bursts.
    always @(posedge i_clk) begin
        t_option opt;
        if (i_rst_n) begin
            if (start && !busy) begin
                opt = pending_options.pop_front();
                expected_prices.push_back(price_option(opt));
            end
            if (idle_left > 0) begin
                idle_left <= idle_left - 1;
                start <= 1'b0;
            end else if (pending_options.size() > 0) begin
                if (idle_on && $urandom_range(0, 3) == 0) begin
                    idle_left <= $urandom_range(0, 5);
                    start <= 1'b0;
                end else begin
                    start <= 1'b1;
                    i_spot_price <= pending_options[0].spot;
                    i_strike_price <= pending_options[0].strike;
                    i_is_put <= pending_options[0].put;
                    i_is_american <= pending_options[0].amer;
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: checks each result word against the oldest expectation.
    always @(posedge i_clk) begin
        logic [31:0] want;
        if (i_rst_n && o_valid) begin
            if (expected_prices.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", o_option_price));
            end else begin
                want = expected_prices.pop_front();
                if (o_option_price !== want) begin
                    report_mismatch($sformatf("option_price %h, expected %h",
                                              o_option_price, want));
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("binomial_option_lattice_tb: done, errors");
            $finish;
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_UP_FACTOR:   sh_up = data;
            CFG_DOWN_FACTOR: sh_down = data;
            CFG_PROB_UP:     sh_prob = data;
            CFG_STEP_DISC:   sh_disc = data;
            CFG_STEPS:       sh_steps = data[8:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_all(input logic [31:0] u, input logic [31:0] d, input logic [31:0] p,
                           input logic [31:0] disc, input logic [8:0] n);
        write_reg(CFG_UP_FACTOR, u);
        write_reg(CFG_DOWN_FACTOR, d);
        write_reg(CFG_PROB_UP, p);
        write_reg(CFG_STEP_DISC, disc);
        write_reg(CFG_STEPS, {23'd0, n});
    endtask

    task automatic add_option(input logic [31:0] s, input logic [31:0] k,
                              input logic put, input logic amer);
        t_option opt;
        opt.spot = s;
        opt.strike = k;
        opt.put = put;
        opt.amer = amer;
        pending_options.push_back(opt);
    endtask

    // Wait until every queued word has been priced and returned.
    task automatic wait_idle();
        do begin
            @(posedge i_clk);
        end while (pending_options.size() > 0 || expected_prices.size() > 0 || busy || start);
    endtask

    task automatic random_option();
        logic [31:0] s;
        logic [31:0] k;
        s = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(32'h0001_0000, 32'h0100_0000);
        case ($urandom_range(0, 3))
            0: k = $urandom;
            1: k = s;
            default: k = s + $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
        endcase
        add_option(s, k, 1'($urandom), 1'($urandom));
    endtask

    initial begin
        logic [31:0] u;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration, field extremes, both kinds and styles.
        add_option(32'd0, 32'd0, 1'b0, 1'b0);
        add_option(32'hFFFF_FFFF, 32'd0, 1'b0, 1'b1);
        add_option(32'd0, 32'hFFFF_FFFF, 1'b1, 1'b0);
        add_option(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
        add_option(32'h0064_0000, 32'h005A_0000, 1'b0, 1'b0);
        add_option(32'h0064_0000, 32'h006E_0000, 1'b1, 1'b1);
        wait_idle();

        // Typical lattice, then out-of-range indexes that must be ignored.
        set_all(32'h4200_0000, 32'h3E00_0000, 32'h4100_0000, 32'h7FF0_0000, 9'd6);
        write_reg(t_cfg_idx'(3'd5), 32'hFFFF_FFFF);
        write_reg(t_cfg_idx'(3'd6), 32'd0);
        write_reg(t_cfg_idx'(3'd7), 32'h1234_5678);
        add_option(32'h0064_0000, 32'h0064_0000, 1'b0, 1'b1);
        add_option(32'h0064_0000, 32'h0064_0000, 1'b1, 1'b1);
        add_option(32'h0064_0000, 32'h0050_0000, 1'b1, 1'b0);
        wait_idle();

        // Price overflow, probability and discount above one.
        set_all(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'd8);
        add_option(32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 1'b0);
        add_option(32'h8000_0000, 32'h0001_0000, 1'b1, 1'b1);
        add_option(32'h0001_0000, 32'h0002_0000, 1'b0, 1'b1);
        wait_idle();

        // Zero probability, zero discount.
        set_all(32'h4800_0000, 32'h3800_0000, 32'd0, 32'd0, 9'd4);
        add_option(32'h0064_0000, 32'h0060_0000, 1'b0, 1'b0);
        add_option(32'h0064_0000, 32'h0070_0000, 1'b1, 1'b1);
        wait_idle();
        write_reg(CFG_PROB_UP, ONE_Q31);
        write_reg(CFG_STEP_DISC, ONE_Q31);
        add_option(32'h0064_0000, 32'h0060_0000, 1'b0, 1'b1);
        wait_idle();

        // Zero steps: root payoff only.
        write_reg(CFG_STEPS, 32'd0);
        add_option(32'h0064_0000, 32'h0060_0000, 1'b0, 1'b0);
        add_option(32'h0064_0000, 32'h0070_0000, 1'b1, 1'b1);
        wait_idle();

        // Step count above the maximum, at its largest and slowest.
        set_all(32'h4040_0000, 32'h3FC0_0000, 32'h4000_0000, 32'h7FFF_0000, 9'h1FF);
        add_option(32'h0064_0000, 32'h0068_0000, 1'b1, 1'b1);
        wait_idle();

        // Random phases, mostly realistic lattices of a few steps.
        for (int ph = 0; ph < 10; ph++) begin
            if (ph == 9) begin
                idle_on = 1'b0;
            end
            if ($urandom_range(0, 4) == 0) begin
                set_all($urandom, $urandom, $urandom, $urandom, 9'($urandom_range(0, 12)));
            end else begin
                u = 32'h4000_0000 + $urandom_range(0, 32'h0400_0000);
                set_all(u, 32'h4000_0000 - $urandom_range(0, 32'h0400_0000),
                        $urandom_range(0, ONE_Q31), 32'h8000_0000 - $urandom_range(0, 32'h0100_0000),
                        9'($urandom_range(1, 12)));
            end
            for (int k = 0; k < 10; k++) begin
                random_option();
            end
            wait_idle();
        end

        repeat (200) @(posedge i_clk);
        if (error_count == 0) begin
            $display("binomial_option_lattice_tb: done, clean");
        end else begin
            $display("binomial_option_lattice_tb: done, errors");
        end
        $finish;
    end

endmodule
